// File: rtl/core/brcd_pkg.sv
// Shared types and constants of the block read cache directory.
// Used by the section map memory and by the top level; depends on nothing.
package brcd_pkg;

    localparam int BSL_W       = 5;
    localparam int FSZ_W       = 40;
    localparam int SCNT_CFG_W  = 5;
    localparam int CFG_W       = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int SLOT_OUT_W  = 4;
    localparam int OFS_W       = 20;
    localparam int FLEN_W      = 21;
    localparam int STAMP_W     = 32;
    localparam int USER_OUT_W  = 4;

    localparam logic [BSL_W-1:0]      BLOCK_LOG2_LIMIT = 5'd20;
    localparam logic [BSL_W-1:0]      RST_BLOCK_LOG2   = 5'd12;
    localparam logic [SCNT_CFG_W-1:0] RST_SLOT_COUNT   = 5'd16;
    localparam logic [STAMP_W-1:0]    FIRST_STAMP      = 32'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LOG2 = 2'd0,
        CFG_FILE_SIZE  = 2'd1,
        CFG_SLOT_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [9:0] {
        S_INIT   = 10'b00_0000_0001,
        S_CLR    = 10'b00_0000_0010,
        S_IDLE   = 10'b00_0000_0100,
        S_FAST   = 10'b00_0000_1000,
        S_MAP    = 10'b00_0001_0000,
        S_SRCH   = 10'b00_0010_0000,
        S_EVICT  = 10'b00_0100_0000,
        S_ATTACH = 10'b00_1000_0000,
        S_UPD    = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    // Result flags; past_end sits in the lowest bit.
    typedef struct packed {
        logic seek_needed;
        logic fill_needed;
        logic fast_hit;
        logic past_end;
    } t_res_flags;

endpackage

// File: rtl/core/brcd_secmap.sv
// Section-to-slot map memory: one write port, one read port, registered read.
// Depends on brcd_pkg for the house types (none needed beyond the import).
module brcd_secmap #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    import brcd_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/block_read_cache_directory_top.sv
// Top level of the block read cache directory.
// Depends on brcd_pkg and brcd_secmap (section map memory).
//
// The directory tracks which buffer slot holds which section of a backing file
// cut into blocks of 2^block_size_log2 bytes. Each input transaction carries a
// byte index; the block answers with one output transaction naming the slot,
// the offset in the block and, when the slot must be loaded, the fill range and
// whether a seek is needed. Items are handled one at a time. A hit in the
// current block or a request past the end goes straight to the output stage,
// a section that already has a slot also passes the map lookup and update,
// and a section without a slot also has a victim searched, evicted and
// replaced; the lowest-priority victim is found by scanning the slot
// priorities one per cycle, and the section map is a single-port-write memory
// with a registered read. After reset and after every configuration write the
// block sweeps the section map and holds tready low.
module block_read_cache_directory_top #(
    parameter int MAX_SECTIONS = 1024,
    parameter int MAX_SLOTS    = 16,
    parameter int INDEX_BITS   = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [brcd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [brcd_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: byte_index
    input  logic [((INDEX_BITS+7)/8)*8-1:0]        i_s_tdata,
    // tuser: make_current
    input  logic                                   i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tdata: slot, block_offset, fill_start, fill_length
    output logic [((INDEX_BITS+45+7)/8)*8-1:0]     o_m_tdata,
    // tuser: past_end, fast_hit, fill_needed, seek_needed
    output logic [brcd_pkg::USER_OUT_W-1:0]        o_m_tuser
);
    import brcd_pkg::*;

    localparam int IW     = INDEX_BITS;
    localparam int AW     = (IW > 20 ? IW : 20) + 1;
    localparam int SEC_AW = MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1;
    localparam int SCNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int SLOT_W = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
    localparam int NSL_W  = $clog2(MAX_SLOTS + 1);
    localparam int TDO_W  = ((IW + SLOT_OUT_W + OFS_W + FLEN_W + 7) / 8) * 8;

    // Configuration registers.
    logic [BSL_W-1:0]      r_bsl;
    logic [FSZ_W-1:0]      r_fsize;
    logic [SCNT_CFG_W-1:0] r_scnt;
    logic                  cfg_hit;

    // Derived configuration.
    logic [BSL_W-1:0]      k;
    logic [IW+FSZ_W-1:0]   fs_ext;
    logic [IW-1:0]         fs;
    logic [AW-1:0]         blk;
    logic [IW-1:0]         low_mask;
    logic [IW:0]           sec_full_cnt;
    logic [SCNT_W-1:0]     r_sec_act;
    logic [NSL_W-1:0]      slots_act;
    logic [IW-1:0]         first_end;
    int                    n_slots;

    // Directory state.
    logic [SEC_AW-1:0]     r_slot_sec  [MAX_SLOTS];
    logic                  r_loaded    [MAX_SLOTS];
    logic [STAMP_W-1:0]    r_prio      [MAX_SLOTS];
    logic [STAMP_W-1:0]    r_nextp;
    logic [SLOT_W-1:0]     r_cur_slot;
    logic [IW-1:0]         r_cur_start;
    logic [IW-1:0]         r_cur_end;
    logic [IW-1:0]         r_last_end;

    // Request in flight.
    t_state                r_state, n_state;
    logic [SEC_AW-1:0]     r_clr;
    logic [IW-1:0]         r_idx;
    logic                  r_mk;
    logic [SEC_AW-1:0]     r_sec;
    logic [IW-1:0]         r_start;
    logic [IW-1:0]         r_end;
    logic [SLOT_W-1:0]     r_s;
    logic [STAMP_W-1:0]    r_best_prio;
    logic [NSL_W-1:0]      r_cnt;

    // Staged and registered result.
    t_res_flags            r_res_flags;
    logic [SLOT_OUT_W-1:0] r_res_slot;
    logic [OFS_W-1:0]      r_res_ofs;
    logic [IW-1:0]         r_res_fstart;
    logic [FLEN_W-1:0]     r_res_flen;
    logic                  r_ov;
    t_res_flags            r_out_flags;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [OFS_W-1:0]      r_out_ofs;
    logic [IW-1:0]         r_out_fstart;
    logic [FLEN_W-1:0]     r_out_flen;

    // Request datapath helpers.
    logic                  fast;
    logic                  past;
    logic [IW-1:0]         sec_idx;
    logic [IW-1:0]         fast_diff;
    logic [IW-1:0]         slow_diff;
    logic [IW+OFS_W-1:0]   fast_ofs_ext;
    logic [IW+OFS_W-1:0]   slow_ofs_ext;
    logic [AW-1:0]         end_sum;
    logic [IW-1:0]         end_min;
    logic [IW+FLEN_W-1:0]  flen_ext;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_out_ext;
    logic [NSL_W-1:0]      map_q;
    logic [NSL_W-1:0]      map_dec;
    logic [NSL_W+SLOT_W-1:0] map_slot_ext;
    logic [NSL_W+SLOT_W-1:0] cnt_ext;
    logic [SLOT_W-1:0]     cnt_slot;
    logic                  map_hit;
    logic                  out_free;
    logic [SEC_AW+SLOT_W-1:0] clr_ext;
    logic [SLOT_W-1:0]     clr_slot;

    // Section map port.
    logic                  m_we;
    logic [SEC_AW-1:0]     m_waddr;
    logic [NSL_W-1:0]      m_wdata;
    logic                  m_re;

    // ---------------------------------------------------------------
    // Configuration and derived values.
    // ---------------------------------------------------------------
    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_BLOCK_LOG2 ||
                                  i_cfg_index == CFG_FILE_SIZE ||
                                  i_cfg_index == CFG_SLOT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsl   <= RST_BLOCK_LOG2;
            r_fsize <= '0;
            r_scnt  <= RST_SLOT_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLOCK_LOG2: r_bsl   <= i_cfg_data[BSL_W-1:0];
                CFG_FILE_SIZE:  r_fsize <= i_cfg_data[FSZ_W-1:0];
                CFG_SLOT_COUNT: r_scnt  <= i_cfg_data[SCNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign k        = (r_bsl > BLOCK_LOG2_LIMIT) ? BLOCK_LOG2_LIMIT : r_bsl;
    assign fs_ext   = {{IW{1'b0}}, r_fsize};
    assign fs       = fs_ext[IW-1:0];
    assign blk      = AW'(1) << k;
    assign low_mask = (IW'(1) << k) - IW'(1);
    assign sec_full_cnt = {1'b0, fs >> k} + (IW+1)'((fs & low_mask) != '0);
    assign first_end = (blk > AW'(fs)) ? fs : blk[IW-1:0];

    // The section count is registered; it settles while the state is S_INIT, before the sweep reads it.
    always_ff @(posedge i_clk) begin
        if (sec_full_cnt > (IW+1)'(MAX_SECTIONS)) begin
            r_sec_act <= SCNT_W'(MAX_SECTIONS);
        end else begin
            r_sec_act <= sec_full_cnt[SCNT_W-1:0];
        end
    end

    always_comb begin
        n_slots = int'(r_scnt);
        if (n_slots < 1) n_slots = 1;
        if (n_slots > MAX_SLOTS) n_slots = MAX_SLOTS;
        if (n_slots > int'(r_sec_act)) n_slots = int'(r_sec_act);
        slots_act = NSL_W'(n_slots);
    end

    // ---------------------------------------------------------------
    // Request datapath.
    // ---------------------------------------------------------------
    assign fast      = (r_idx >= r_cur_start) && (r_idx < r_cur_end);
    assign sec_idx   = r_idx >> k;
    assign past      = (r_idx >= fs) ||
                       ({{SCNT_W{1'b0}}, sec_idx} >= {{IW{1'b0}}, r_sec_act});
    assign fast_diff = r_idx - r_cur_start;
    assign slow_diff = r_idx - r_start;
    assign fast_ofs_ext = {{OFS_W{1'b0}}, fast_diff};
    assign slow_ofs_ext = {{OFS_W{1'b0}}, slow_diff};
    assign end_sum   = AW'(r_start) + blk;
    assign end_min   = (end_sum > AW'(fs)) ? fs : end_sum[IW-1:0];
    assign flen_ext  = {{FLEN_W{1'b0}}, r_end - r_start};
    assign slot_out_ext = {{SLOT_OUT_W{1'b0}}, r_s};

    // A map entry holds slot + 1, zero when the section has no slot.
    assign map_dec      = map_q - NSL_W'(1);
    assign map_slot_ext = {{SLOT_W{1'b0}}, map_dec};
    assign map_hit      = (map_q != '0) && (map_q <= slots_act);
    assign cnt_ext      = {{SLOT_W{1'b0}}, r_cnt};
    assign cnt_slot     = cnt_ext[SLOT_W-1:0];
    assign clr_ext      = {{SLOT_W{1'b0}}, r_clr};
    assign clr_slot     = clr_ext[SLOT_W-1:0];
    assign out_free     = !r_ov || i_m_tready;

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_clr;
        m_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = (32'(r_clr) < 32'(slots_act)) ?
                          NSL_W'(32'(r_clr) + 32'd1) : '0;
            end
            S_EVICT: begin
                m_we    = 1'b1;
                m_waddr = r_slot_sec[r_s];
                m_wdata = '0;
            end
            S_ATTACH: begin
                m_we    = 1'b1;
                m_waddr = r_sec;
                m_wdata = NSL_W'(32'(r_s) + 32'd1);
            end
            default: ;
        endcase
    end

    assign m_re = (r_state == S_FAST);

    brcd_secmap #(
        .DEPTH (MAX_SECTIONS),
        .AW    (SEC_AW),
        .DW    (NSL_W)
    ) u_secmap (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (sec_idx[SEC_AW-1:0]),
        .o_rdata (map_q)
    );

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:   n_state = S_CLR;
            S_CLR:    if (r_clr == SEC_AW'(MAX_SECTIONS - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_s_tvalid && o_s_tready) n_state = S_FAST;
            S_FAST:   n_state = (fast || past) ? S_OUT : S_MAP;
            S_MAP: begin
                if (map_hit) begin
                    n_state = S_UPD;
                end else if (slots_act <= NSL_W'(1)) begin
                    n_state = S_EVICT;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH:   if (r_cnt == slots_act - NSL_W'(1)) n_state = S_EVICT;
            S_EVICT:  n_state = S_ATTACH;
            S_ATTACH: n_state = S_UPD;
            S_UPD:    n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_INIT;
        endcase
        if (cfg_hit) begin
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_INIT: begin
                // Section 0 counts as filled, unless the file is empty, and is the current block.
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    r_slot_sec[i] <= '0;
                    r_loaded[i]   <= (i == 0) && (fs != '0);
                    r_prio[i]     <= STAMP_W'((i == 0) && (fs != '0));
                end
                r_nextp      <= FIRST_STAMP;
                r_cur_slot   <= '0;
                r_cur_start  <= '0;
                r_cur_end    <= first_end;
                r_last_end   <= first_end;
                r_clr        <= '0;
            end
            S_CLR: begin
                if (32'(r_clr) < 32'(slots_act)) begin
                    r_slot_sec[clr_slot] <= r_clr;
                end
                r_clr <= r_clr + SEC_AW'(1);
            end
            S_IDLE: begin
                r_idx <= i_s_tdata[IW-1:0];
                r_mk  <= i_s_tuser;
            end
            S_FAST: begin
                r_sec   <= sec_idx[SEC_AW-1:0];
                r_start <= r_idx & ~low_mask;
                r_res_flags.seek_needed <= 1'b0;
                r_res_flags.fill_needed <= 1'b0;
                r_res_flags.fast_hit    <= fast;
                r_res_flags.past_end    <= !fast && past;
                r_res_slot   <= fast ? SLOT_OUT_W'(32'(r_cur_slot)) : '0;
                r_res_ofs    <= fast ? fast_ofs_ext[OFS_W-1:0] : '0;
                r_res_fstart <= '0;
                r_res_flen   <= '0;
            end
            S_MAP: begin
                r_end       <= end_min;
                r_s         <= map_hit ? map_slot_ext[SLOT_W-1:0] : '0;
                r_best_prio <= r_prio[0];
                r_cnt       <= NSL_W'(1);
            end
            S_SRCH: begin
                // Strict compare keeps the lowest index on a tie.
                if (r_prio[cnt_slot] < r_best_prio) begin
                    r_s         <= cnt_slot;
                    r_best_prio <= r_prio[cnt_slot];
                end
                r_cnt <= r_cnt + NSL_W'(1);
            end
            S_EVICT: begin
                if (r_s == r_cur_slot) begin
                    r_cur_start <= '0;
                    r_cur_end   <= '0;
                end
                r_slot_sec[r_s] <= r_sec;
                r_loaded[r_s]   <= 1'b0;
            end
            S_UPD: begin
                if (!r_loaded[r_s]) begin
                    r_loaded[r_s] <= 1'b1;
                    r_res_flags.fill_needed <= 1'b1;
                    r_res_flags.seek_needed <= (r_start != r_last_end);
                    r_res_fstart <= r_start;
                    r_res_flen   <= flen_ext[FLEN_W-1:0];
                    r_last_end   <= r_end;
                end
                r_prio[r_s] <= r_nextp;
                r_nextp     <= r_nextp + STAMP_W'(1);
                if (r_mk) begin
                    r_cur_slot  <= r_s;
                    r_cur_start <= r_start;
                    r_cur_end   <= r_end;
                end
                r_res_slot <= slot_out_ext[SLOT_OUT_W-1:0];
                r_res_ofs  <= slow_ofs_ext[OFS_W-1:0];
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_flags  <= r_res_flags;
                    r_out_slot   <= r_res_slot;
                    r_out_ofs    <= r_res_ofs;
                    r_out_fstart <= r_res_fstart;
                    r_out_flen   <= r_res_flen;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Ports.
    // ---------------------------------------------------------------
    assign o_s_tready = (r_state == S_IDLE) && !i_cfg_we;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = TDO_W'({r_out_flen, r_out_fstart, r_out_ofs, r_out_slot});
    assign o_m_tuser  = r_out_flags;

endmodule

// File: tb/brcd_checker.sv
// Checker of the block read cache directory: it watches the configuration port and
// both stream channels, predicts each result and compares it field by field.
// Depends on brcd_pkg.
`timescale 1ns / 100ps

module brcd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [87:0] i_m_tdata,
    input  logic [3:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    import brcd_pkg::*;

    localparam int SECTIONS = 1024;
    localparam int SLOTS    = 16;
    localparam longint unsigned IDX_MASK = 64'hFF_FFFF_FFFF;

    typedef struct {
        bit          past_end;
        bit          fast_hit;
        bit [3:0]    slot;
        bit [19:0]   block_offset;
        bit          fill_needed;
        bit [39:0]   fill_start;
        bit [20:0]   fill_length;
        bit          seek_needed;
    } t_lookup;

    bit [4:0]        reg_log2;
    longint unsigned reg_fsize;
    bit [4:0]        reg_slots;

    bit [4:0]        sec_map [SECTIONS];
    int unsigned     slot_sec [SLOTS];
    bit              loaded [SLOTS];
    bit [31:0]       stamp [SLOTS];
    bit [31:0]       next_stamp;
    int unsigned     cur_slot;
    longint unsigned cur_start, cur_end, prev_fill_end;
    longint unsigned n_sections;
    int unsigned     n_slots;

    t_lookup lookups_due[$];

    function automatic int unsigned blk_shift();
        return (reg_log2 > 20) ? 20 : reg_log2;
    endfunction

    function automatic longint unsigned sect_end(longint unsigned s);
        longint unsigned e;
        e = (s << blk_shift()) + (64'd1 << blk_shift());
        return (e > reg_fsize) ? reg_fsize : e;
    endfunction

    // Any register write rebuilds the directory from scratch.
    function automatic void rebuild_directory();
        int unsigned k;
        longint unsigned n;
        k = blk_shift();
        n_sections = (reg_fsize >> k) + (((reg_fsize & ((64'd1 << k) - 1)) != 0) ? 1 : 0);
        if (n_sections > SECTIONS) n_sections = SECTIONS;
        n = reg_slots;
        if (n < 1) n = 1;
        if (n > SLOTS) n = SLOTS;
        if (n > n_sections) n = n_sections;
        n_slots = n;
        foreach (sec_map[i]) sec_map[i] = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_sec[i] = 0;
            loaded[i]   = 0;
            stamp[i]    = '0;
        end
        for (int i = 0; i < n_slots; i++) begin
            sec_map[i]  = i + 1;
            slot_sec[i] = i;
        end
        next_stamp    = 32'd2;
        cur_slot      = 0;
        cur_start     = 0;
        cur_end       = 0;
        prev_fill_end = 0;
        if (n_slots > 0) begin
            loaded[0]     = 1;
            stamp[0]      = 32'd1;
            cur_end       = sect_end(0);
            prev_fill_end = cur_end;
        end
    endfunction

    function automatic t_lookup resolve_lookup(longint unsigned idx, bit mk);
        t_lookup r;
        longint unsigned sec, st, en;
        int unsigned s;
        r = '{default: 0};
        if (idx >= cur_start && idx < cur_end) begin
            r.fast_hit     = 1;
            r.slot         = cur_slot;
            r.block_offset = idx - cur_start;
            return r;
        end
        sec = idx >> blk_shift();
        if (idx >= reg_fsize || sec >= n_sections) begin
            r.past_end = 1;
            return r;
        end
        st = sec << blk_shift();
        en = sect_end(sec);
        if (sec_map[sec] != 0 && (sec_map[sec] - 1) < n_slots) begin
            s = sec_map[sec] - 1;
        end else begin
            // Victim is the oldest stamp, lowest slot on a tie.
            s = 0;
            for (int i = 1; i < n_slots; i++)
                if (stamp[i] < stamp[s]) s = i;
            if (slot_sec[s] < SECTIONS) sec_map[slot_sec[s]] = 0;
            if (s == cur_slot) begin
                cur_start = 0;
                cur_end   = 0;
            end
            slot_sec[s] = sec;
            sec_map[sec] = s + 1;
            loaded[s] = 0;
        end
        if (!loaded[s]) begin
            loaded[s]     = 1;
            r.fill_needed = 1;
            r.fill_start  = st;
            r.fill_length = en - st;
            r.seek_needed = (st != prev_fill_end);
            prev_fill_end = en;
        end
        stamp[s]   = next_stamp;
        next_stamp = next_stamp + 1;
        if (mk) begin
            cur_slot  = s;
            cur_start = st;
            cur_end   = en;
        end
        r.slot         = s;
        r.block_offset = idx - st;
        return r;
    endfunction

    assign o_pending = lookups_due.size();

    always @(posedge i_clk) begin
        t_lookup exp_r;
        if (!i_rst_n) begin
            reg_log2     = RST_BLOCK_LOG2;
            reg_fsize    = 0;
            reg_slots    = RST_SLOT_COUNT;
            rebuild_directory();
            lookups_due.delete();
            o_fail_count = 0;
        end else begin
            // An output transaction always belongs to an earlier request, so it is
            // matched before a request accepted at the same edge is predicted.
            if (i_m_tvalid && i_m_tready) begin
                if (lookups_due.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count++;
                end else begin
                    exp_r = lookups_due.pop_front();
                    if (i_m_tuser[0] !== exp_r.past_end) begin
                        $error("past_end exp %0d got %0d", exp_r.past_end, i_m_tuser[0]);
                        o_fail_count++;
                    end
                    if (i_m_tuser[1] !== exp_r.fast_hit) begin
                        $error("fast_hit exp %0d got %0d", exp_r.fast_hit, i_m_tuser[1]);
                        o_fail_count++;
                    end
                    if (i_m_tuser[2] !== exp_r.fill_needed) begin
                        $error("fill_needed exp %0d got %0d", exp_r.fill_needed, i_m_tuser[2]);
                        o_fail_count++;
                    end
                    if (i_m_tuser[3] !== exp_r.seek_needed) begin
                        $error("seek_needed exp %0d got %0d", exp_r.seek_needed, i_m_tuser[3]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[3:0] !== exp_r.slot) begin
                        $error("slot exp %0d got %0d", exp_r.slot, i_m_tdata[3:0]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[23:4] !== exp_r.block_offset) begin
                        $error("block_offset exp %0h got %0h", exp_r.block_offset,
                               i_m_tdata[23:4]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[63:24] !== exp_r.fill_start) begin
                        $error("fill_start exp %0h got %0h", exp_r.fill_start,
                               i_m_tdata[63:24]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[84:64] !== exp_r.fill_length) begin
                        $error("fill_length exp %0h got %0h", exp_r.fill_length,
                               i_m_tdata[84:64]);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                lookups_due.push_back(resolve_lookup(i_s_tdata & IDX_MASK, i_s_tuser));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_LOG2: reg_log2  = i_cfg_data[4:0];
                    CFG_FILE_SIZE:  reg_fsize = i_cfg_data;
                    CFG_SLOT_COUNT: reg_slots = i_cfg_data[4:0];
                    default: ;
                endcase
                if (i_cfg_index inside {CFG_BLOCK_LOG2, CFG_FILE_SIZE, CFG_SLOT_COUNT})
                    rebuild_directory();
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the block read cache directory testbench: clock, reset, stimulus and verdict.
// Depends on brcd_pkg, block_read_cache_directory_top and brcd_checker.
`timescale 1ns / 100ps

module tb_top;
    import brcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    // The block clears its section map after each register write.
    localparam int SWEEP_WAIT = 1100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [39:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [87:0] o_m_tdata;
    logic [3:0]  o_m_tuser;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_mode;
    bit use_gaps;

    // Shadow of the programmed registers, used only to aim the requests.
    int unsigned     cur_log2;
    longint unsigned cur_fsize;
    int unsigned     cur_slots;
    longint unsigned last_idx;

    block_read_cache_directory_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    brcd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // The result side stalls on its own pattern; the mode changes per phase so that
    // some phases see no back-pressure at all and others see heavy stalling.
    always @(negedge i_clk) begin
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 3) != 0);
            2:       i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // The watchdog ends the run if neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL block_read_cache_directory_top");
            $finish;
        end
    end

    // A register write reinitializes the directory; the block then sweeps its map.
    task automatic write_reg(t_cfg_idx idx, longint unsigned value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        repeat (SWEEP_WAIT) @(negedge i_clk);
    endtask

    // Changes settings only once every outstanding result has come back.
    task automatic program_directory(int unsigned log2v, longint unsigned fsz,
                                     int unsigned slots);
        i_s_tvalid = 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        write_reg(CFG_BLOCK_LOG2, log2v);
        write_reg(CFG_FILE_SIZE, fsz);
        write_reg(CFG_SLOT_COUNT, slots);
        cur_log2  = log2v;
        cur_fsize = fsz;
        cur_slots = slots;
        last_idx  = 0;
    endtask

    // Presents one request transaction and holds it until accepted, then maybe
    // leaves a gap before the next one.
    task automatic send_request(longint unsigned idx, bit mk);
        int gap;
        i_s_tvalid = 1'b1;
        i_s_tdata  = idx;
        i_s_tuser  = mk;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        gap = (use_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        last_idx = idx;
    endtask

    // Most requests land in a small window of sections so that slots get reused and
    // evicted; the rest are neighbors of the last byte, just past the file size,
    // anywhere in the file, or arbitrary indexes that are mostly past the end.
    function automatic longint unsigned pick_index();
        int unsigned k;
        longint unsigned blk, nsec, sec;
        int unsigned r;
        k    = (cur_log2 > 20) ? 20 : cur_log2;
        blk  = 64'd1 << k;
        nsec = (cur_fsize + blk - 1) >> k;
        if (nsec > 1024) nsec = 1024;
        r = $urandom_range(0, 99);
        if (nsec == 0 || r >= 92)
            return {$urandom(), $urandom()} & 64'hFF_FFFF_FFFF;
        if (r < 60) begin
            sec = $urandom_range(0, (nsec > cur_slots + 4) ? cur_slots + 4 : nsec - 1);
            return (sec << k) + ({$urandom(), $urandom()} & (blk - 1));
        end
        if (r < 80)
            return (last_idx ^ ($urandom() & (blk - 1))) & 64'hFF_FFFF_FFFF;
        if (r < 86)
            return cur_fsize + $urandom_range(0, 3);
        return {$urandom(), $urandom()} % ((nsec << k) < cur_fsize ? (nsec << k) : cur_fsize);
    endfunction

    task automatic random_phase(int unsigned log2v, longint unsigned fsz,
                                int unsigned slots, int count);
        program_directory(log2v, fsz, slots);
        stall_mode = $urandom_range(0, 3);
        use_gaps   = $urandom_range(0, 2) != 0;
        for (int n = 0; n < count; n++)
            send_request(pick_index(), $urandom_range(0, 1));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_BLOCK_LOG2;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        stall_mode  = 0;
        use_gaps    = 1'b0;
        cur_log2    = 12;
        cur_fsize   = 0;
        cur_slots   = 16;
        last_idx    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SWEEP_WAIT) @(negedge i_clk);

        // Out of reset the file is empty, so every request is past the end.
        send_request(0, 0);
        send_request(64'hFF_FFFF_FFFF, 1);

        // Seven sections of 16 bytes, the last only four long, and three slots:
        // fast hits, a mapped slot that needs its fill, a short last section,
        // past-end requests, and evictions that take out the current block.
        program_directory(4, 100, 3);
        stall_mode = 1;
        use_gaps   = 1'b1;
        send_request(0, 0);
        send_request(15, 1);
        send_request(16, 1);
        send_request(17, 0);
        send_request(99, 0);
        send_request(100, 0);
        send_request(64'hFF_FFFF_FFFF, 0);
        send_request(32, 0);
        send_request(48, 1);
        send_request(64, 0);
        send_request(80, 0);
        send_request(96, 1);
        send_request(0, 0);
        send_request(31, 0);
        send_request(98, 1);

        random_phase(0, 40, 2, 140);
        random_phase(12, 0, 16, 30);
        random_phase(20, 64'hFF_FFFF_FFFF, 16, 150);
        random_phase(31, 5000000, 31, 150);
        random_phase(3, 1000, 1, 150);
        random_phase(5, 64'hFF_FFFF_FFFF, 0, 150);
        random_phase(2, 37, 16, 140);
        random_phase(6, 4000, 8, 150);
        random_phase(1, 2049, 5, 150);
        random_phase(9, 64'h12_3456_789A, 17, 130);

        i_s_tvalid = 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS block_read_cache_directory_top");
        else
            $display("FAIL block_read_cache_directory_top");
        $finish;
    end

endmodule
